/* rtl/lgf_pkg.sv */
// shared constants and types for the local grid to global map fusion block
// no dependencies
`default_nettype none

package lgf_pkg;

    localparam int MAP_SIZE  = 256;
    localparam int FRAC_BITS = 8;

    localparam int MAP_AW    = $clog2(MAP_SIZE);
    localparam int CELL_AW   = 2 * MAP_AW;
    localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int COORD_W   = (MAP_AW > 8) ? MAP_AW : 8;

    // Q2.14 trig plus Q.FRAC_BITS position
    localparam int SHIFT     = FRAC_BITS + 14;

    localparam int CFG_W     = 25;
    localparam int RX_W      = 30;
    localparam int PROD_W    = RX_W + 16;
    localparam int SUM_W     = PROD_W + 2;
    localparam int HI_W      = SUM_W - SHIFT;

    localparam logic signed [7:0] COST_SKIP = -8'sd1;

    typedef enum logic {
        OP_MERGE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_COS_YAW  = 3'd0,
        CFG_SIN_YAW  = 3'd1,
        CFG_STEP     = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_POSE_X   = 3'd5,
        CFG_POSE_Y   = 3'd6,
        CFG_UNUSED   = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

/* rtl/local_grid_fuse_into_global_map.sv */
// top level: fuses local grid cells into the global occupancy map by signed max
// depends on lgf_pkg and lgf_ram
// result: strobe o_done is registered in the merge step, the last step of the sequence
// requests: taken one at a time and only while idle, the sequencer stepping through
//   scale, rotate, sum, range check and the map ram read-modify-write
// reset: a clearing pass writes MAP_SIZE*MAP_SIZE (65536) zero cells, busy stays high
// the receiver cannot stall; each result is shown for one cycle only
`default_nettype none

module local_grid_fuse_into_global_map
    import lgf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_cfg_we,
    input  wire logic [2:0]              i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_op,
    input  wire logic [11:0]             i_local_col,
    input  wire logic [11:0]             i_local_row,
    input  wire logic signed [7:0]       i_cell_cost,
    input  wire logic [7:0]              i_read_col,
    input  wire logic [7:0]              i_read_row,
    output logic                         o_done,
    output logic                         o_in_bounds,
    output logic                         o_updated,
    output logic [7:0]                   o_global_col,
    output logic [7:0]                   o_global_row,
    output logic signed [7:0]            o_cell_out
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCALE,
        S_ROTATE,
        S_SUM,
        S_RANGE,
        S_MERGE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [15:0]      r_cos;
    logic signed [15:0]      r_sin;
    logic [15:0]             r_step;
    logic signed [CFG_W-1:0] r_org_x;
    logic signed [CFG_W-1:0] r_org_y;
    logic signed [CFG_W-1:0] r_pose_x;
    logic signed [CFG_W-1:0] r_pose_y;

    // request
    logic                    r_op;
    logic [11:0]             r_col;
    logic [11:0]             r_row;
    logic signed [7:0]       r_cost;
    logic [7:0]              r_read_col;
    logic [7:0]              r_read_row;

    // datapath
    logic signed [RX_W-1:0]   r_rx;
    logic signed [RX_W-1:0]   r_ry;
    logic signed [PROD_W-1:0] r_pxc;
    logic signed [PROD_W-1:0] r_pys;
    logic signed [PROD_W-1:0] r_pxs;
    logic signed [PROD_W-1:0] r_pyc;
    logic signed [SUM_W-1:0]  r_sx;
    logic signed [SUM_W-1:0]  r_sy;
    logic                     r_ok;
    logic [MAP_AW-1:0]        r_gx;
    logic [MAP_AW-1:0]        r_gy;
    logic [CELL_AW-1:0]       r_clr_addr;

    logic                     n_ok;
    logic [MAP_AW-1:0]        n_gx;
    logic [MAP_AW-1:0]        n_gy;
    logic                     x_ok;
    logic                     y_ok;
    logic [MAP_AW-1:0]        x_idx;
    logic [MAP_AW-1:0]        y_idx;
    logic [27:0]              scale_x;
    logic [27:0]              scale_y;

    logic                     ram_we;
    logic [CELL_AW-1:0]       ram_waddr;
    logic [7:0]               ram_wdata;
    logic [7:0]               ram_rdata;
    logic signed [7:0]        cur_cell;
    logic signed [7:0]        new_cell;
    logic                     do_write;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= 16'sd16384;
            r_sin    <= '0;
            r_step   <= 16'd256;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_pose_x <= '0;
            r_pose_y <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COS_YAW:  r_cos    <= i_cfg_data[15:0];
                CFG_SIN_YAW:  r_sin    <= i_cfg_data[15:0];
                CFG_STEP:     r_step   <= i_cfg_data[15:0];
                CFG_ORIGIN_X: r_org_x  <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y  <= i_cfg_data;
                CFG_POSE_X:   r_pose_x <= i_cfg_data;
                CFG_POSE_Y:   r_pose_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign scale_x = r_col * r_step;
    assign scale_y = r_row * r_step;

    // truncation toward zero: a negative sum above -1.0 lands on index 0
    always_comb begin
        if (!r_sx[SUM_W-1]) begin
            x_ok  = HI_W'(r_sx[SUM_W-1:SHIFT]) < HI_W'(MAP_SIZE);
            x_idx = r_sx[SHIFT+MAP_AW-1:SHIFT];
        end else begin
            x_ok  = (&r_sx[SUM_W-1:SHIFT]) && (|r_sx[SHIFT-1:0]);
            x_idx = '0;
        end
        if (!r_sy[SUM_W-1]) begin
            y_ok  = HI_W'(r_sy[SUM_W-1:SHIFT]) < HI_W'(MAP_SIZE);
            y_idx = r_sy[SHIFT+MAP_AW-1:SHIFT];
        end else begin
            y_ok  = (&r_sy[SUM_W-1:SHIFT]) && (|r_sy[SHIFT-1:0]);
            y_idx = '0;
        end
        if (r_op == OP_READ) begin
            n_ok = ((COORD_W+1)'(r_read_col) < (COORD_W+1)'(MAP_SIZE))
                && ((COORD_W+1)'(r_read_row) < (COORD_W+1)'(MAP_SIZE));
            n_gx = COORD_W'(r_read_col) & {MAP_AW{1'b1}};
            n_gy = COORD_W'(r_read_row) & {MAP_AW{1'b1}};
        end else begin
            n_ok = x_ok && y_ok;
            n_gx = x_idx;
            n_gy = y_idx;
        end
    end

    assign cur_cell = ram_rdata;
    assign new_cell = (r_cost > cur_cell) ? r_cost : cur_cell;
    assign do_write = (r_state == S_MERGE) && r_ok && (r_op == OP_MERGE)
                      && (r_cost != COST_SKIP);

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = do_write;
            ram_waddr = {r_gy, r_gx};
            ram_wdata = new_cell;
        end
    end

    lgf_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({n_gy, n_gx}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            o_done     <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op       <= i_op;
                        r_col      <= i_local_col;
                        r_row      <= i_local_row;
                        r_cost     <= i_cell_cost;
                        r_read_col <= i_read_col;
                        r_read_row <= i_read_row;
                        r_state    <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_rx    <= signed'({2'b00, scale_x}) + RX_W'(r_org_x);
                    r_ry    <= signed'({2'b00, scale_y}) + RX_W'(r_org_y);
                    r_state <= S_ROTATE;
                end
                S_ROTATE: begin
                    r_pxc   <= r_rx * r_cos;
                    r_pys   <= r_ry * r_sin;
                    r_pxs   <= r_rx * r_sin;
                    r_pyc   <= r_ry * r_cos;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sx    <= SUM_W'(r_pxc) - SUM_W'(r_pys) + (SUM_W'(r_pose_x) <<< 14);
                    r_sy    <= SUM_W'(r_pxs) + SUM_W'(r_pyc) + (SUM_W'(r_pose_y) <<< 14);
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    // map ram read is issued here, data arrives in merge
                    r_ok    <= n_ok;
                    r_gx    <= n_gx;
                    r_gy    <= n_gy;
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    o_done      <= 1'b1;
                    o_in_bounds <= r_ok;
                    o_updated   <= do_write;
                    o_global_col <= r_ok ? COORD_W'(r_gx) & 8'hFF : '0;
                    o_global_row <= r_ok ? COORD_W'(r_gy) & 8'hFF : '0;
                    if (!r_ok) begin
                        o_cell_out <= '0;
                    end else if (do_write) begin
                        o_cell_out <= new_cell;
                    end else begin
                        o_cell_out <= cur_cell;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result only ever follows the merge step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_MERGE))
        else $error("result strobe without a merge step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_updated |-> o_in_bounds)
        else $error("update reported outside the map");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_in_bounds |->
            (o_cell_out == 8'sd0) && (o_global_col == 8'd0) && (o_global_row == 8'd0))
        else $error("out of bounds result carries nonzero fields");

    // the map is written only by the clearing pass or a valid merge
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR)
            || ((r_state == S_MERGE) && r_ok && (r_op == OP_MERGE)))
        else $error("unexpected map write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> busy && !o_done)
        else $error("block not busy during clearing pass");

endmodule

`default_nettype wire

/* rtl/lgf_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
